[src/pbla_pkg.sv]
// Shared types and constants for the PCI BAR largest-first allocator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package pbla_pkg;

	localparam int SLOT_W = 5;
	localparam int BAR_W  = 3;
	localparam int DATA_W = 32;

	localparam int MAX_DEVICES_DEF     = 10;
	localparam int BARS_PER_DEVICE_DEF = 6;

	localparam logic [DATA_W-1:0] MIN_ALIGN = 32'h0000_1000;
	localparam logic [DATA_W-1:0] IO_MASK   = 32'hffff_fffc;
	localparam logic [DATA_W-1:0] MEM_MASK  = 32'hffff_fff0;

	// APB register indexes (paddr[2])
	localparam logic REG_MEM_BASE = 1'b0;
	localparam logic REG_IO_BASE  = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] size;
		logic              io;
		logic [SLOT_W-1:0] slot;
		logic [BAR_W-1:0]  bar;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} cell_t;

	// Broadcast to every cell of the sorted chain
	typedef struct packed {
		logic   insert;
		logic   pop;
		logic   clear;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

[src/pbla_if.sv]
// Valid/ready channel interfaces for BAR descriptions and assignments.
// Depends on pbla_pkg.
`timescale 1ns / 1ps

interface pbla_bar_in_if;
	import pbla_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot_number;
	logic [BAR_W-1:0]  bar_index;
	logic [DATA_W-1:0] original_value;
	logic [DATA_W-1:0] sizing_readback;
	logic              last_entry;

	modport source (output valid, slot_number, bar_index, original_value, sizing_readback,
		last_entry, input ready);
	modport sink (input valid, slot_number, bar_index, original_value, sizing_readback,
		last_entry, output ready);
endinterface

interface pbla_bar_out_if;
	import pbla_pkg::*;
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] out_slot;
	logic [BAR_W-1:0]  out_bar;
	logic [DATA_W-1:0] assigned_value;
	logic              is_io;
	logic              final_result;

	modport source (output valid, out_slot, out_bar, assigned_value, is_io, final_result,
		input ready);
	modport sink (input valid, out_slot, out_bar, assigned_value, is_io, final_result,
		output ready);
endinterface

[src/pci_bar_largest_first_allocator_core.sv]
// Top level of the PCI BAR largest-first allocator: APB registers, input
// register, sorted cell chain and allocation sequencer. Depends on pbla_pkg,
// pbla_if and pbla_cell.
`timescale 1ns / 1ps

// BAR descriptions arrive one word at a time on bar_in and are kept in a row of
// MAX_DEVICES*BARS_PER_DEVICE cells sorted by size, largest at the head; a new
// word is placed behind all entries of equal or larger size, so equal sizes come
// out in load order. Words beyond capacity are dropped. Each word is registered,
// then inserted into the chain in one shift.
// A word with last_entry set starts allocation: the memory and I/O cursors are
// loaded from mem_window_base and io_window_base, and the head cell is popped
// while it holds a nonzero size. Each assignment runs PICK (pick and pop the
// head), ALIGN (align the cursor) and SEND (advance the cursor and fill the
// output register, held while bar_out stalls); a PICK with no live head ends the
// run and empties the chain. bar_in is ready only while no run is in progress,
// but a finished assignment may still wait in the output register. Alignment is
// max(0x1000, size); addresses wrap at 32 bits. I/O assignments carry bit 0 set.
// Registers: 0x0 mem_window_base, 0x4 io_window_base (decoded by paddr[2]).
module pci_bar_largest_first_allocator_core #(
	parameter int MAX_DEVICES     = pbla_pkg::MAX_DEVICES_DEF,
	parameter int BARS_PER_DEVICE = pbla_pkg::BARS_PER_DEVICE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [pbla_pkg::DATA_W-1:0] pwdata,
	output logic [pbla_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	pbla_bar_in_if.sink                 bar_in,
	pbla_bar_out_if.source              bar_out
);
	import pbla_pkg::*;

	localparam int CAP   = MAX_DEVICES * BARS_PER_DEVICE;
	localparam int CNT_W = $clog2(CAP + 1);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INS   = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_ALIGN = 3'd3;
	localparam logic [2:0] ST_SEND  = 3'd4;

	logic [2:0] state_q;

	// configuration registers
	logic [DATA_W-1:0] mem_base_q;
	logic [DATA_W-1:0] io_base_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_IO_BASE) ? io_base_q : mem_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= '0;
			io_base_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MEM_BASE: mem_base_q <= pwdata;
				REG_IO_BASE:  io_base_q  <= pwdata;
				default:      mem_base_q <= mem_base_q;
			endcase
		end
	end

	// input word register
	logic [SLOT_W-1:0] in_slot_q;
	logic [BAR_W-1:0]  in_bar_q;
	logic              in_io_q;
	logic [DATA_W-1:0] in_rb_q;
	logic              in_last_q;
	logic              in_acc;

	assign bar_in.ready = (state_q == ST_IDLE);
	assign in_acc       = bar_in.valid && bar_in.ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_slot_q <= bar_in.slot_number;
			in_bar_q  <= bar_in.bar_index;
			in_io_q   <= bar_in.original_value[0];
			in_rb_q   <= bar_in.sizing_readback;
			in_last_q <= bar_in.last_entry;
		end
	end

	// size = two's complement of the masked readback
	entry_t new_entry;
	always_comb begin
		new_entry.size = -(in_rb_q & (in_io_q ? IO_MASK : MEM_MASK));
		new_entry.io   = in_io_q;
		new_entry.slot = in_slot_q;
		new_entry.bar  = in_bar_q;
	end

	// sorted cell chain
	logic [CNT_W-1:0] count_q;
	logic             full;
	cell_ctl_t        ctl;
	cell_t            cells [CAP];
	logic             gts   [CAP];
	cell_t            head;
	logic             head_live;

	assign full      = (count_q == CNT_W'(CAP));
	assign head      = cells[0];
	assign head_live = head.valid && (head.entry.size != '0);

	assign ctl.insert    = (state_q == ST_INS) && !full;
	assign ctl.pop       = (state_q == ST_PICK) && head_live;
	assign ctl.clear     = (state_q == ST_PICK) && !head_live;
	assign ctl.new_entry = new_entry;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		cell_t prev_c;
		cell_t next_c;
		logic  prev_g;
		if (i == 0) begin : g_first
			assign prev_c = '0;
			assign prev_g = 1'b0;
		end else begin : g_mid
			assign prev_c = cells[i-1];
			assign prev_g = gts[i-1];
		end
		if (i == CAP - 1) begin : g_last
			assign next_c = '0;
		end else begin : g_inner
			assign next_c = cells[i+1];
		end
		pbla_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_cell (prev_c),
			.prev_gt   (prev_g),
			.next_cell (next_c),
			.cur       (cells[i]),
			.gt        (gts[i])
		);
	end

	// allocation datapath
	logic [DATA_W-1:0] mem_cur_q;
	logic [DATA_W-1:0] io_cur_q;
	logic [DATA_W-1:0] amask_q;   // alignment - 1
	logic [DATA_W-1:0] base_q;
	logic              pick_io_q;
	logic [SLOT_W-1:0] pick_slot_q;
	logic [BAR_W-1:0]  pick_bar_q;
	logic [DATA_W-1:0] cur_sel;
	logic [DATA_W-1:0] align_a;
	logic [DATA_W-1:0] next_cur;
	logic              out_free;

	assign cur_sel  = pick_io_q ? io_cur_q : mem_cur_q;
	assign align_a  = (head.entry.size > MIN_ALIGN) ? head.entry.size : MIN_ALIGN;
	// base is aligned, so base + a == (base | (a-1)) + 1
	assign next_cur = (base_q | amask_q) + DATA_W'(1);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_PICK: begin
				amask_q     <= align_a - DATA_W'(1);
				pick_io_q   <= head.entry.io;
				pick_slot_q <= head.entry.slot;
				pick_bar_q  <= head.entry.bar;
			end
			ST_ALIGN: base_q <= (cur_sel + amask_q) & ~amask_q;
			default: base_q <= base_q;
		endcase
	end

	// output register
	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [BAR_W-1:0]  out_bar_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_io_q;
	logic              out_final_q;

	assign out_free = !out_valid_q || bar_out.ready;

	assign bar_out.valid          = out_valid_q;
	assign bar_out.out_slot       = out_slot_q;
	assign bar_out.out_bar        = out_bar_q;
	assign bar_out.assigned_value = out_value_q;
	assign bar_out.is_io          = out_io_q;
	assign bar_out.final_result   = out_final_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SEND && out_free) begin
			out_slot_q  <= pick_slot_q;
			out_bar_q   <= pick_bar_q;
			out_value_q <= base_q | DATA_W'(pick_io_q);
			out_io_q    <= pick_io_q;
			out_final_q <= !head_live;  // chain already popped: head is the next pick
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mem_cur_q   <= '0;
			io_cur_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word replaces the one leaving, else the register empties on ready
			if (state_q == ST_SEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (bar_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
					if (in_last_q) begin
						mem_cur_q <= mem_base_q;
						io_cur_q  <= io_base_q;
						state_q   <= ST_PICK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PICK: begin
					if (head_live) begin
						state_q <= ST_ALIGN;
					end else begin
						count_q   <= '0;
						mem_cur_q <= '0;
						io_cur_q  <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_ALIGN: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						if (pick_io_q) begin
							io_cur_q <= next_cur;
						end else begin
							mem_cur_q <= next_cur;
						end
						state_q <= ST_PICK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/pbla_cell.sv]
// One cell of the sorted insertion chain: holds one BAR entry.
// Depends on pbla_pkg.
`timescale 1ns / 1ps

module pbla_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pbla_pkg::cell_ctl_t ctl,
	input  pbla_pkg::cell_t    prev_cell,
	input  logic               prev_gt,
	input  pbla_pkg::cell_t    next_cell,
	output pbla_pkg::cell_t    cur,
	output logic               gt
);
	import pbla_pkg::*;

	logic   valid_q;
	entry_t entry_q;
	logic   valid_d;
	entry_t entry_d;

	assign cur = '{valid: valid_q, entry: entry_q};

	// New word belongs ahead of this cell (strictly larger, so ties stay in load order)
	assign gt = !valid_q || (ctl.new_entry.size > entry_q.size);

	always_comb begin
		valid_d = valid_q;
		entry_d = entry_q;
		priority if (ctl.clear) begin
			valid_d = 1'b0;
		end else if (ctl.pop) begin
			valid_d = next_cell.valid;
			entry_d = next_cell.entry;
		end else if (ctl.insert && gt && prev_gt) begin
			valid_d = prev_cell.valid;
			entry_d = prev_cell.entry;
		end else if (ctl.insert && gt) begin
			valid_d = 1'b1;
			entry_d = ctl.new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

[src/pbla_checker.sv]
// Port-level assertions for the BAR allocator, bound to the top level.
// Depends on pci_bar_largest_first_allocator_core.
`timescale 1ns / 1ps

module pbla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] assigned_value,
	input logic        is_io,
	input logic        final_result
);

	// a word in flight blocks the next one
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted back to back");

	// I/O flag agrees with bit 0 of the value
	a_io_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (assigned_value[0] == is_io))
		else $error("is_io does not match assigned_value bit 0");

	// every alignment is a multiple of 4, so bit 1 of a base is always clear
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (assigned_value[1] == 1'b0))
		else $error("assigned base has bit 1 set");

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(assigned_value) && $stable(final_result)))
		else $error("output word changed while stalled");

endmodule

bind pci_bar_largest_first_allocator_core pbla_checker u_pbla_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (bar_in.valid),
	.in_ready       (bar_in.ready),
	.out_valid      (bar_out.valid),
	.out_ready      (bar_out.ready),
	.assigned_value (bar_out.assigned_value),
	.is_io          (bar_out.is_io),
	.final_result   (bar_out.final_result)
);

[tb/tb_top.sv]
// Self-checking testbench for pci_bar_largest_first_allocator_core: drives BAR
// words and APB window writes, predicts the largest-first assignments in-line.
// Depends on pbla_pkg, pbla_if and the core RTL.
`timescale 1ns / 1ps

module tb_top;
	import pbla_pkg::*;

	localparam int STORE_DEPTH  = MAX_DEVICES_DEF * BARS_PER_DEVICE_DEF;
	localparam int DRAIN_CYCLES = 20;     // covers the run wrap-up after the last result
	localparam int HOLD_CYCLES  = 400;    // long sink back-pressure stretch
	localparam int LIMIT_CYCLES = 200000;

	// One BAR description as offered on bar_in
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [BAR_W-1:0]  bar;
		logic [DATA_W-1:0] orig;
		logic [DATA_W-1:0] readback;
		logic              last;
	} bar_word_t;

	// One expected assignment on bar_out
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [BAR_W-1:0]  bar;
		logic [DATA_W-1:0] value;
		logic              io;
		logic              fin;
	} assignment_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	pbla_bar_in_if  bar_in_ch ();
	pbla_bar_out_if bar_out_ch ();

	pci_bar_largest_first_allocator_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.bar_in  (bar_in_ch),
		.bar_out (bar_out_ch)
	);

	// Predictor state: shadow of the window registers and of the BAR store
	logic [DATA_W-1:0] mem_window_shadow;
	logic [DATA_W-1:0] io_window_shadow;
	entry_t            bar_store[$];
	assignment_t       expected_assignments[$];

	bar_word_t pending_bars[$];
	bar_word_t drive_word;
	int unsigned words_queued;
	int unsigned words_accepted;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	logic offering;     // driver currently holds a word on bar_in
	logic in_took;      // that word was accepted at the last rising edge
	logic hold_arm;
	logic sink_hold;

	always #5 clk = ~clk;

	// Store one BAR; on the last word walk the store largest first and queue
	// every nonzero assignment. Ties keep load order (strict > picks earliest).
	function automatic void absorb_bar(input bar_word_t w);
		entry_t            e;
		assignment_t       r;
		logic [DATA_W-1:0] masked;
		logic [DATA_W-1:0] best;
		logic [DATA_W-1:0] align;
		logic [DATA_W-1:0] base;
		logic [DATA_W-1:0] mem_cur;
		logic [DATA_W-1:0] io_cur;
		int                pick;
		int                n;
		bit                done;
		if (bar_store.size() < STORE_DEPTH) begin
			e.io   = w.orig[0];
			masked = w.readback & (e.io ? IO_MASK : MEM_MASK);
			e.size = ~masked + 32'd1;
			e.slot = w.slot;
			e.bar  = w.bar;
			bar_store.push_back(e);
		end
		if (!w.last)
			return;
		mem_cur = mem_window_shadow;
		io_cur  = io_window_shadow;
		n       = 0;
		done    = 1'b0;
		while (!done) begin
			best = '0;
			pick = 0;
			for (int i = 0; i < bar_store.size(); i++) begin
				if (bar_store[i].size > best) begin
					best = bar_store[i].size;
					pick = i;
				end
			end
			if (best == '0) begin
				done = 1'b1;
			end else begin
				align = (best > MIN_ALIGN) ? best : MIN_ALIGN;
				e     = bar_store[pick];
				// align up may exceed 2^32 and wrap; all math stays 32 bit
				if (e.io) begin
					base   = (io_cur + align - 32'd1) & ~(align - 32'd1);
					io_cur = base + align;
				end else begin
					base    = (mem_cur + align - 32'd1) & ~(align - 32'd1);
					mem_cur = base + align;
				end
				r.slot  = e.slot;
				r.bar   = e.bar;
				r.value = e.io ? (base | 32'd1) : base;
				r.io    = e.io;
				r.fin   = 1'b0;
				expected_assignments.push_back(r);
				e.size          = '0;
				bar_store[pick] = e;
				n++;
			end
		end
		if (n > 0) begin
			r     = expected_assignments.pop_back();
			r.fin = 1'b1;
			expected_assignments.push_back(r);
		end
		bar_store.delete();
	endfunction

	// Mostly plausible BARs (power-of-two size, right type bits), some raw noise
	function automatic bar_word_t random_bar();
		bar_word_t   w;
		int unsigned k;
		logic [DATA_W-1:0] span;
		w.slot     = SLOT_W'($urandom_range(31));
		w.bar      = BAR_W'($urandom_range(7));
		w.last     = 1'b0;
		w.orig     = $urandom;
		w.readback = $urandom;
		if ($urandom_range(99) < 85) begin
			if ($urandom_range(3) == 0) begin
				k          = $urandom_range(8, 2);
				span       = 32'd1 << k;
				w.orig[0]  = 1'b1;
				w.readback = ~(span - 32'd1) | (w.readback & 32'h3);
			end else begin
				k          = ($urandom_range(9) == 0) ? $urandom_range(31, 21)
				                                     : $urandom_range(20, 4);
				span       = 32'd1 << k;
				w.orig[0]  = 1'b0;
				w.readback = ~(span - 32'd1) | (w.readback & 32'hf);
			end
			// unimplemented BAR: only type bits read back, size comes out zero
			if ($urandom_range(9) == 0)
				w.readback = w.readback & (w.orig[0] ? 32'h3 : 32'hf);
		end
		return w;
	endfunction

	task automatic add_bar(input bar_word_t w);
		pending_bars.push_back(w);
		words_queued++;
	endtask

	task automatic add_fixed(input logic [SLOT_W-1:0] slot, input logic [BAR_W-1:0] bar,
		input logic [DATA_W-1:0] orig, input logic [DATA_W-1:0] readback, input logic last);
		bar_word_t w;
		w = '{slot: slot, bar: bar, orig: orig, readback: readback, last: last};
		add_bar(w);
	endtask

	// n random BARs, the last one closing the run
	task automatic add_random_run(input int n);
		bar_word_t w;
		for (int i = 0; i < n; i++) begin
			w      = random_bar();
			w.last = (i == n - 1);
			add_bar(w);
		end
	endtask

	// APB write: setup then access; register updates on the access edge
	task automatic write_window(input logic reg_sel, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_sel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (reg_sel == REG_MEM_BASE)
			mem_window_shadow = value;
		else
			io_window_shadow = value;
	endtask

	// Idle point: every word in, every assignment out, run wrap-up finished
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_accepted != words_queued || expected_assignments.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_field(input string name, input logic [DATA_W-1:0] exp_v,
		input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// Driver: a word stays on bar_in until taken; gaps only between words
	always @(negedge clk) begin
		if (!offering || in_took) begin
			in_took = 1'b0;
			if (pending_bars.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				drive_word                <= pending_bars.pop_front();
				bar_in_ch.valid           <= 1'b1;
				offering                   = 1'b1;
			end else begin
				bar_in_ch.valid <= 1'b0;
				offering         = 1'b0;
			end
		end
	end

	assign bar_in_ch.slot_number     = drive_word.slot;
	assign bar_in_ch.bar_index       = drive_word.bar;
	assign bar_in_ch.original_value  = drive_word.orig;
	assign bar_in_ch.sizing_readback = drive_word.readback;
	assign bar_in_ch.last_entry      = drive_word.last;

	// Sink ready: random stalls, forced low during the hold-off stretch
	always @(negedge clk)
		bar_out_ch.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);

	// Hold-off: once armed, block the sink for a long stretch from the first
	// result, so the output register fills and bar_in stalls behind it
	initial begin
		wait (hold_arm);
		@(posedge clk);
		while (!bar_out_ch.valid)
			@(posedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// Monitor: feed accepted words to the predictor, check accepted results
	always @(posedge clk) begin
		assignment_t exp_a;
		if (arst_n && bar_in_ch.valid && bar_in_ch.ready) begin
			absorb_bar(drive_word);
			words_accepted++;
			in_took = 1'b1;
		end
		if (arst_n && bar_out_ch.valid && bar_out_ch.ready) begin
			if (expected_assignments.size() == 0) begin
				$display("%0t: unexpected assignment: expected none actual slot %h bar %h value %h",
					$time, bar_out_ch.out_slot, bar_out_ch.out_bar, bar_out_ch.assigned_value);
				mismatches++;
			end else begin
				exp_a = expected_assignments.pop_front();
				report_field("out_slot", 32'(exp_a.slot), 32'(bar_out_ch.out_slot));
				report_field("out_bar", 32'(exp_a.bar), 32'(bar_out_ch.out_bar));
				report_field("assigned_value", exp_a.value, bar_out_ch.assigned_value);
				report_field("is_io", 32'(exp_a.io), 32'(bar_out_ch.is_io));
				report_field("final_result", 32'(exp_a.fin), 32'(bar_out_ch.final_result));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		drive_word        = '0;
		bar_in_ch.valid   = 1'b0;
		bar_out_ch.ready  = 1'b0;
		mem_window_shadow = '0;
		io_window_shadow  = '0;
		words_queued      = 0;
		words_accepted    = 0;
		mismatches        = 0;
		cycle_count       = 0;
		offering          = 1'b0;
		in_took           = 1'b0;
		hold_arm          = 1'b0;
		sink_hold         = 1'b0;
		src_idle_pct      = 10;
		snk_idle_pct      = 74;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: mixed run covering field extremes, ties, zero size,
		// non power-of-two size, odd slot/bar codes and both spaces
		write_window(REG_MEM_BASE, 32'h8000_0000);
		write_window(REG_IO_BASE, 32'h0000_1000);
		add_fixed(5'd0, 3'd0, 32'h0000_0000, 32'hffff_f000, 1'b0);
		add_fixed(5'd31, 3'd7, 32'h0000_0001, 32'hffff_ff01, 1'b0);
		add_fixed(5'd1, 3'd6, 32'h0000_0000, 32'h0000_0000, 1'b0);
		add_fixed(5'd2, 3'd1, 32'h0000_0008, 32'hffff_f00c, 1'b0);
		add_fixed(5'd3, 3'd2, 32'hffff_fffe, 32'hffff_3000, 1'b0);
		add_fixed(5'd4, 3'd5, 32'h0000_0000, 32'h8000_0000, 1'b0);
		add_fixed(5'd5, 3'd3, 32'h0000_0001, 32'hffff_fffd, 1'b0);
		add_fixed(5'd6, 3'd4, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		// run with only zero sizes: no assignment, store still cleared
		add_fixed(5'd7, 3'd0, 32'h0000_0000, 32'h0000_000f, 1'b0);
		add_fixed(5'd8, 3'd1, 32'h0000_0001, 32'h0000_0003, 1'b1);
		// lone last word of the smallest memory size
		add_fixed(5'd9, 3'd2, 32'h0000_0000, 32'hffff_fff0, 1'b1);
		wait_drained();

		// Windows at the top: the first base in each space wraps past 2^32
		write_window(REG_MEM_BASE, 32'hffff_ffff);
		write_window(REG_IO_BASE, 32'hffff_ffff);
		add_fixed(5'd10, 3'd0, 32'h0000_0000, 32'h0000_0010, 1'b0);
		add_fixed(5'd11, 3'd1, 32'h0000_0001, 32'hffff_0001, 1'b0);
		add_fixed(5'd12, 3'd2, 32'h0000_0000, 32'hffff_f000, 1'b0);
		add_fixed(5'd13, 3'd3, 32'h0000_0001, 32'hffff_fffc, 1'b1);
		wait_drained();

		// Random, sender mostly busy, sink stalling a lot
		write_window(REG_MEM_BASE, 32'h0000_0000);
		write_window(REG_IO_BASE, 32'h0000_0000);
		for (int r = 0; r < 5; r++)
			add_random_run($urandom_range(12, 1));
		wait_drained();

		// Store overflow run under a long sink hold, then more runs queued
		// behind it so bar_in backs up
		src_idle_pct = 74;
		snk_idle_pct = 10;
		write_window(REG_MEM_BASE, $urandom);
		write_window(REG_IO_BASE, $urandom);
		hold_arm = 1'b1;
		add_random_run(STORE_DEPTH + 4);
		add_random_run($urandom_range(8, 2));
		add_random_run($urandom_range(8, 2));
		wait_drained();

		// Random, no idling on either side
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_window(REG_MEM_BASE, $urandom);
		write_window(REG_IO_BASE, $urandom);
		for (int r = 0; r < 3; r++)
			add_random_run($urandom_range(10, 1));
		wait_drained();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
